@@ rtl/gbfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfd_pkg
// Types and constants of the gray background frame difference core.
// ----------------------------------------------------------------------------
package gbfd_pkg;

   localparam int INDEX_W = 19;
   localparam int PIX_W   = 8;

   // Gray conversion weights, sum of weights is 256.
   localparam logic [15:0] WEIGHT_BLUE  = 16'd29;
   localparam logic [15:0] WEIGHT_GREEN = 16'd150;
   localparam logic [15:0] WEIGHT_RED   = 16'd77;

   localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd40;

   typedef enum logic [0:0] {
      CSR_GRAY_INPUT     = 1'b0,
      CSR_DIFF_THRESHOLD = 1'b1
   } csr_index_type;

endpackage

@@ rtl/gray_background_frame_difference_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_background_frame_difference_core
// Gray conversion and motion detection against background and previous frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel per transaction (index and BGR bytes in tdata, end of
//   frame on tlast). rsp_* returns one result per pixel in order: gray value and
//   the two motion bits in tdata, the learning flag in tuser. csr_* writes gray_input
//   (index 0) and diff_threshold (index 1); the user writes only while idle (not checked).
// Timing:
//   A request transaction is registered in stage 1, then in the result register
//   that drives result valid. One pixel per cycle is sustained while rsp_tready
//   is high; the rate is set by the single read and single write port of each
//   frame store, with a read-modify-write of the previous frame store per pixel
//   and forwarding between back to back pixels that hit the same index.
// Reset:
//   Clears the pipeline, the learned-background flag and the registers
//   (gray_input 0, diff_threshold 40). The next frame is learned into both
//   stores. The stores have no clearing pass.
// Stall:
//   When rsp_tready is low the result register holds and the pipeline stops;
//   req_tready drops once the stage behind the store read is also full.
// ----------------------------------------------------------------------------
module gray_background_frame_difference_core
   import gbfd_pkg::*;
#(
   parameter int MAX_PIXELS = 524288
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,   // pixel_index[18:0], blue, green, red, zero pad
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // gray_value[7:0], background_motion,
                                             // previous_motion, zero pad
   output logic [0:0]           rsp_tuser,   // learning
   input  logic                 csr_we,
   input  logic [0:0]           csr_addr,
   input  logic [PIX_W-1:0]     csr_wdata
);

   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int EXT_W  = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              in_range;
      logic [PIX_W-1:0]  gray;
      logic              eof;
   } stage_type;

   // configuration
   logic             gray_input_ff;
   logic [PIX_W-1:0] threshold_ff;

   // stores
   logic [PIX_W-1:0] bg_mem   [MAX_PIXELS];
   logic [PIX_W-1:0] prev_mem [MAX_PIXELS];
   logic [PIX_W-1:0] bg_rd_ff;
   logic [PIX_W-1:0] prev_rd_ff;

   // forwarding of the write that coincides with the read
   logic             fwd_prev_ff;
   logic             fwd_bg_ff;
   logic [PIX_W-1:0] fwd_gray_ff;
   logic             fwd_prev_in;
   logic             fwd_bg_in;

   // pipeline
   logic             s1_valid_ff;
   logic             s1_valid_in;
   stage_type        s1_ff;
   stage_type        s1_in;
   logic             bg_valid_ff;
   logic             bg_valid_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [PIX_W-1:0] rsp_gray_ff;
   logic             rsp_bg_motion_ff;
   logic             rsp_prev_motion_ff;
   logic             rsp_learning_ff;

   logic             accept;
   logic             commit;
   logic             learning;
   logic [EXT_W-1:0] idx_ext;
   logic [15:0]      gray_sum;
   logic [PIX_W-1:0] bg_val;
   logic [PIX_W-1:0] prev_val;
   logic [PIX_W-1:0] bg_diff;
   logic [PIX_W-1:0] prev_diff;
   logic             bg_motion;
   logic             prev_motion;

   // ---------------------------------------------------------------- control
   assign commit     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || commit;
   assign accept     = req_tvalid && req_tready;
   assign learning   = !bg_valid_ff;

   // ---------------------------------------------------------------- stage 0
   always_comb begin
      idx_ext  = EXT_W'(req_tdata[INDEX_W-1:0]);
      gray_sum = WEIGHT_BLUE  * {8'd0, req_tdata[26:19]}
               + WEIGHT_GREEN * {8'd0, req_tdata[34:27]}
               + WEIGHT_RED   * {8'd0, req_tdata[42:35]};
      s1_in.addr     = idx_ext[ADDR_W-1:0];
      s1_in.in_range = idx_ext < EXT_W'(MAX_PIXELS);
      s1_in.gray     = gray_input_ff ? req_tdata[26:19] : gray_sum[15:8];
      s1_in.eof      = req_tlast;
      fwd_prev_in    = commit && s1_ff.in_range && (s1_ff.addr == s1_in.addr);
      fwd_bg_in      = fwd_prev_in && learning;
      s1_valid_in    = accept || (s1_valid_ff && !commit);
   end

   // ---------------------------------------------------------------- stores
   always_ff @(posedge clock) begin
      if (commit && s1_ff.in_range) begin
         prev_mem[s1_ff.addr] <= s1_ff.gray;
      end
      if (accept) begin
         prev_rd_ff <= prev_mem[s1_in.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (commit && s1_ff.in_range && learning) begin
         bg_mem[s1_ff.addr] <= s1_ff.gray;
      end
      if (accept) begin
         bg_rd_ff <= bg_mem[s1_in.addr];
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      prev_val = !s1_ff.in_range ? '0 : (fwd_prev_ff ? fwd_gray_ff : prev_rd_ff);
      bg_val   = !s1_ff.in_range ? '0 : (fwd_bg_ff   ? fwd_gray_ff : bg_rd_ff);
      bg_diff   = (s1_ff.gray >= bg_val)   ? s1_ff.gray - bg_val   : bg_val - s1_ff.gray;
      prev_diff = (s1_ff.gray >= prev_val) ? s1_ff.gray - prev_val : prev_val - s1_ff.gray;
      bg_motion   = !learning && (bg_diff > threshold_ff);
      prev_motion = !learning && (prev_diff > threshold_ff);
      bg_valid_in  = bg_valid_ff || (commit && learning && s1_ff.eof);
      rsp_valid_in = commit || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bg_valid_ff   <= 1'b0;
         fwd_prev_ff   <= 1'b0;
         fwd_bg_ff     <= 1'b0;
         gray_input_ff <= 1'b0;
         threshold_ff  <= THRESHOLD_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         bg_valid_ff  <= bg_valid_in;
         if (accept) begin
            fwd_prev_ff <= fwd_prev_in;
            fwd_bg_ff   <= fwd_bg_in;
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_GRAY_INPUT:     gray_input_ff <= csr_wdata[0];
               CSR_DIFF_THRESHOLD: threshold_ff  <= csr_wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= s1_in;
         fwd_gray_ff <= s1_ff.gray;
      end
      if (commit) begin
         rsp_gray_ff        <= s1_ff.gray;
         rsp_bg_motion_ff   <= bg_motion;
         rsp_prev_motion_ff <= prev_motion;
         rsp_learning_ff    <= learning;
      end
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_prev_motion_ff, rsp_bg_motion_ff, rsp_gray_ff};
   assign rsp_tuser  = rsp_learning_ff;

   // ---------------------------------------------------------------- checks
   a_learning_no_motion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_learning_ff |-> !rsp_bg_motion_ff && !rsp_prev_motion_ff)
      else $error("motion reported during learning");

   a_bg_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      bg_valid_ff |=> bg_valid_ff)
      else $error("background flag dropped without reset");

   a_fwd_bg_implies_prev: assert property (@(posedge clock) disable iff (reset)
      fwd_bg_ff |-> fwd_prev_ff)
      else $error("background forward without previous forward");

   a_commit_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed transaction lost before result register");

   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !accept)
      else $error("transaction accepted into a stalled stage");

endmodule
